>>> rtl/core/fpfa_pkg.sv
package fpfa_pkg;

  // Fixed widths of the item fields
  localparam int unsigned PART_IDX_W = 4;
  localparam int unsigned PART_NUM_W = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // Reset value of the partitions-in-use register
  localparam logic [CFG_DATA_W-1:0] PARTS_IN_USE_RESET = 5'd16;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2
  } strategy_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRATEGY     = 1'b0,
    CFG_PARTS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req_alloc;
    logic scan_empty;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> rtl/core/fpfa_req_if.sv
interface fpfa_req_if #(
  parameter int unsigned SIZE_BITS = 16
);
  import fpfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [PART_IDX_W-1:0] part_index;
  logic [SIZE_BITS-1:0]  amount;

  modport source (output valid, operation, part_index, amount, input ready);
  modport sink   (input valid, operation, part_index, amount, output ready);
endinterface

>>> rtl/core/fpfa_rsp_if.sv
interface fpfa_rsp_if #(
  parameter int unsigned SIZE_BITS = 16
);
  import fpfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [PART_NUM_W-1:0] part_number;
  logic [SIZE_BITS-1:0]  remaining_after;

  modport source (output valid, granted, part_number, remaining_after, input ready);
  modport sink   (input valid, granted, part_number, remaining_after, output ready);
endinterface

>>> rtl/core/fpfa_ram.sv
module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fpfa_ctrl.sv
module fpfa_ctrl
  import fpfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.req_alloc && !sts_i.scan_empty) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_TAIL;
        end
      end
      // The last read returns and is compared here.
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/fpfa_dp.sv
module fpfa_dp
  import fpfa_pkg::*;
#(
  parameter int unsigned NUM_PARTS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  operation_i,
  input  logic [PART_IDX_W-1:0] part_index_i,
  input  logic [SIZE_BITS-1:0]  amount_i,
  input  ctl_cmd_t              cmd_i,
  output ctl_sts_t              sts_o,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic                  granted_o,
  output logic [PART_NUM_W-1:0] part_number_o,
  output logic [SIZE_BITS-1:0]  remaining_after_o
);

  localparam int unsigned IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_PARTS + 1);
  localparam int unsigned LIM_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int unsigned SUM_W = IDX_W + 1;

  // Configuration registers
  logic [1:0]            strategy_q;
  logic [CFG_DATA_W-1:0] parts_q;

  // Captured transaction
  logic                  op_q;
  logic [PART_IDX_W-1:0] idx_q;
  logic [SIZE_BITS-1:0]  amt_q;

  // Scan state
  logic [IDX_W-1:0]      cnt_q;
  logic                  cmp_en_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic                  found_q;
  logic [IDX_W-1:0]      sel_q;
  logic [SIZE_BITS-1:0]  selv_q;
  logic [NUM_PARTS-1:0]  vld_q;
  logic                  rd_vld_q;

  // Result register
  logic                  out_valid_q;
  logic                  granted_q;
  logic [PART_NUM_W-1:0] pn_q;
  logic [SIZE_BITS-1:0]  rem_q;

  logic [LIM_W-1:0]      parts_ext;
  logic [LIM_W-1:0]      limit;
  logic [SIZE_BITS-1:0]  rd_data;
  logic [SIZE_BITS-1:0]  cur;
  logic                  fits;
  logic                  take;
  logic                  load_ok;
  logic [SIZE_BITS-1:0]  new_rem;
  logic [SUM_W-1:0]      sel_p1;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;

  // Remainder table; entries never written read as zero via the valid bits.
  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_PARTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= STRAT_FIRST;
      parts_q    <= PARTS_IN_USE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRATEGY:     strategy_q <= cfg_data_i[1:0];
        CFG_PARTS_IN_USE: parts_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Number of entries to scan, limited to the table size
  assign parts_ext = LIM_W'(parts_q);
  assign limit     = (parts_ext > LIM_W'(NUM_PARTS)) ? LIM_W'(NUM_PARTS) : parts_ext;

  assign sts_o.req_alloc  = (operation_i == OP_ALLOC);
  assign sts_o.scan_empty = (limit == '0);
  assign sts_o.scan_last  = ((LIM_W'(cnt_q) + LIM_W'(1)) == limit);
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  // Candidate compare on the entry read in the previous cycle
  assign cur  = rd_vld_q ? rd_data : '0;
  assign fits = (cur >= amt_q);
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (strategy_q == STRAT_BEST) begin
        take = (cur < selv_q);
      end else if (strategy_q == STRAT_WORST) begin
        take = (cur > selv_q);
      end
    end
  end

  // Capture, scan counter and running choice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_en_q <= 1'b0;
      found_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cmp_en_q <= cmd_i.scan_step;
      if (cmd_i.capture) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          cnt_q <= cnt_q + IDX_W'(1);
        end
        if (cmp_en_q && take) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      idx_q <= part_index_i;
      amt_q <= amount_i;
    end
    if (cmd_i.scan_step) begin
      cmp_idx_q <= cnt_q;
    end
    if (cmp_en_q && take) begin
      sel_q  <= cmp_idx_q;
      selv_q <= cur;
    end
  end

  // Valid bit per entry, and the valid bit of the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[cnt_q];
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Write-back of the loaded or reduced entry
  assign load_ok = ({{(32 - PART_IDX_W){1'b0}}, idx_q} < 32'(NUM_PARTS));
  assign new_rem = selv_q - amt_q;
  assign sel_p1  = SUM_W'(sel_q) + SUM_W'(1);

  always_comb begin
    if (op_q == OP_LOAD) begin
      wr_en   = cmd_i.finish && load_ok;
      wr_addr = IDX_W'(idx_q);
      wr_data = amt_q;
    end else begin
      wr_en   = cmd_i.finish && found_q;
      wr_addr = sel_q;
      wr_data = new_rem;
    end
  end

  // Result register; a new transaction may be taken while it waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (wr_en) begin
        granted_q <= 1'b1;
        rem_q     <= wr_data;
        if (op_q == OP_LOAD) begin
          pn_q <= PART_NUM_W'(idx_q) + PART_NUM_W'(1);
        end else begin
          pn_q <= PART_NUM_W'(sel_p1);
        end
      end else begin
        granted_q <= 1'b0;
        pn_q      <= '0;
        rem_q     <= '0;
      end
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign granted_o         = granted_q;
  assign part_number_o     = pn_q;
  assign remaining_after_o = rem_q;

endmodule

>>> rtl/core/fixed_partition_fit_allocator_core.sv
// Fixed-partition fit allocator. A load transaction sets the free size of one partition;
// an allocate transaction asks for an amount, and the partition picked by the configured
// rule (first, best or worst fit over the partitions in use) is reduced by it and reported
// by its 1-based number, or 0 when nothing fits. Every input transaction gives exactly one
// result transaction. A load goes straight to the result; a request scans the first
// min(parts_in_use, NUM_PARTS) entries of the remainder table, which has a single read
// port and is scanned one entry per cycle, before the chosen entry is written back.
// The table reads as zero after reset with no clearing pass. A finished result waits in
// an output register while the next transaction is taken. Configuration is to be written
// by the user only while the block is idle; the block itself does not enforce this.
module fixed_partition_fit_allocator_core
  import fpfa_pkg::*;
#(
  parameter int unsigned NUM_PARTS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fpfa_req_if.sink              req_i,
  fpfa_rsp_if.source            rsp_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer
  fpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, compare logic and result register
  fpfa_dp #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (req_i.operation),
    .part_index_i      (req_i.part_index),
    .amount_i          (req_i.amount),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .granted_o         (rsp_o.granted),
    .part_number_o     (rsp_o.part_number),
    .remaining_after_o (rsp_o.remaining_after)
  );

endmodule

>>> rtl/core/fpfa_checker.sv
module fpfa_checker
  import fpfa_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  rsp_granted_i,
  input logic [PART_NUM_W-1:0] rsp_part_number_i,
  input logic [SIZE_BITS-1:0]  rsp_remaining_i
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_i)
      && $stable(rsp_part_number_i) && $stable(rsp_remaining_i))
    else $error("Stalled result changed");

  // A refused transaction reports nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_granted_i |-> rsp_part_number_i == '0 && rsp_remaining_i == '0)
    else $error("Refused result carries a partition or size");

  // A granted transaction names a real partition.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_granted_i |-> rsp_part_number_i != '0)
    else $error("Granted result without a partition number");

  // Only one transaction is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("Input taken while a transaction is in progress");

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker #(
  .SIZE_BITS (SIZE_BITS)
) u_fpfa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_granted_i     (rsp_o.granted),
  .rsp_part_number_i (rsp_o.part_number),
  .rsp_remaining_i   (rsp_o.remaining_after)
);

>>> dv/tb_fixed_partition_fit_allocator_core.sv
module tb_fixed_partition_fit_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fpfa_pkg::*;

  localparam int unsigned NUM_PARTS      = 16;
  localparam int unsigned SIZE_BITS      = 16;
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned PHASE_ITEMS    = 170;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // The strategy register is two bits wide; the fourth code has no name in the package.
  localparam logic [1:0] STRAT_UNUSED = 2'd3;

  typedef struct packed {
    logic                  granted;
    logic [PART_NUM_W-1:0] part_number;
    logic [SIZE_BITS-1:0]  remaining_after;
  } grant_t;

  localparam grant_t NOT_GRANTED = '0;

  typedef enum logic [1:0] {
    DIR_LOAD,
    DIR_ALLOC,
    DIR_CFG
  } dir_kind_e;

  // One directed step: a load, a request or a register write. For a register write,
  // sel holds the register index and val the value written.
  typedef struct packed {
    dir_kind_e             kind;
    logic [PART_IDX_W-1:0] sel;
    logic [SIZE_BITS-1:0]  val;
    logic                  typed_check;
    grant_t                want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 29;

  // Directed steps, starting from the reset configuration (first fit, all partitions).
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{DIR_ALLOC, 4'd0,  16'd1,      1'b1, NOT_GRANTED},
    '{DIR_ALLOC, 4'd15, 16'd0,      1'b1, '{1'b1, 5'd1, 16'd0}},
    '{DIR_LOAD,  4'd0,  16'hFFFF,   1'b1, '{1'b1, 5'd1, 16'hFFFF}},
    '{DIR_LOAD,  4'd15, 16'h8000,   1'b1, '{1'b1, 5'd16, 16'h8000}},
    '{DIR_ALLOC, 4'd0,  16'hFFFF,   1'b1, '{1'b1, 5'd1, 16'd0}},
    '{DIR_ALLOC, 4'd0,  16'h8001,   1'b1, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'h8000,   1'b1, '{1'b1, 5'd16, 16'd0}},
    '{DIR_LOAD,  4'd3,  16'd100,    1'b1, '{1'b1, 5'd4, 16'd100}},
    '{DIR_LOAD,  4'd7,  16'd100,    1'b1, '{1'b1, 5'd8, 16'd100}},
    '{DIR_LOAD,  4'd9,  16'd300,    1'b1, '{1'b1, 5'd10, 16'd300}},
    '{DIR_LOAD,  4'd12, 16'd50,     1'b1, '{1'b1, 5'd13, 16'd50}},
    '{DIR_ALLOC, 4'd5,  16'd40,     1'b1, '{1'b1, 5'd4, 16'd60}},
    '{DIR_CFG,   PART_IDX_W'(CFG_STRATEGY), SIZE_BITS'(STRAT_BEST), 1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd50,     1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd60,     1'b0, NOT_GRANTED},
    '{DIR_LOAD,  4'd5,  16'd100,    1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd10,     1'b0, NOT_GRANTED},
    '{DIR_CFG,   PART_IDX_W'(CFG_STRATEGY), SIZE_BITS'(STRAT_WORST), 1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd1,      1'b0, NOT_GRANTED},
    '{DIR_LOAD,  4'd10, 16'd299,    1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd1,      1'b0, NOT_GRANTED},
    '{DIR_CFG,   PART_IDX_W'(CFG_STRATEGY), SIZE_BITS'(STRAT_UNUSED), 1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd1,      1'b0, NOT_GRANTED},
    '{DIR_CFG,   PART_IDX_W'(CFG_PARTS_IN_USE), 16'd0,  1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'd0,      1'b1, NOT_GRANTED},
    '{DIR_LOAD,  4'd2,  16'd7,      1'b1, '{1'b1, 5'd3, 16'd7}},
    '{DIR_CFG,   PART_IDX_W'(CFG_PARTS_IN_USE), 16'd31, 1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd10, 16'h0100,   1'b0, NOT_GRANTED},
    '{DIR_ALLOC, 4'd0,  16'hA5A5,   1'b0, NOT_GRANTED}
  };

  // Configuration of each random phase.
  localparam logic [1:0] PHASE_RULE [NUM_PHASES] = '{
    STRAT_FIRST, STRAT_BEST, STRAT_WORST, STRAT_UNUSED, STRAT_BEST,
    STRAT_WORST, STRAT_FIRST, STRAT_BEST, STRAT_WORST
  };
  localparam logic [CFG_DATA_W-1:0] PHASE_PARTS [NUM_PHASES] = '{
    5'd16, 5'd16, 5'd16, 5'd7, 5'd1, 5'd31, 5'd16, 5'd12, 5'd20
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fpfa_req_if #(.SIZE_BITS(SIZE_BITS)) req_if ();
  fpfa_rsp_if #(.SIZE_BITS(SIZE_BITS)) rsp_if ();

  fixed_partition_fit_allocator_core #(
    .NUM_PARTS (NUM_PARTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // Our own copy of the partition table and configuration.
  logic [SIZE_BITS-1:0]  free_left [NUM_PARTS];
  logic [1:0]            fit_rule;
  logic [CFG_DATA_W-1:0] active_parts;

  grant_t      grant_q [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_now(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int unsigned live_parts();
    return (active_parts > NUM_PARTS) ? NUM_PARTS : active_parts;
  endfunction

  // Works out the result of one accepted transaction and updates the table copy.
  function automatic grant_t predict_grant(op_e op, logic [PART_IDX_W-1:0] idx,
                                           logic [SIZE_BITS-1:0] amt);
    grant_t      g;
    int          pick;
    int unsigned j;
    g = NOT_GRANTED;
    if (op == OP_LOAD) begin
      free_left[idx]    = amt;
      g.granted         = 1'b1;
      g.part_number     = {1'b0, idx} + 5'd1;
      g.remaining_after = amt;
      return g;
    end
    pick = -1;
    for (j = 0; j < live_parts(); j++) begin
      if (free_left[j] >= amt) begin
        if (pick < 0) begin
          pick = j;
          // First fit, and the unused code, stop at the lowest fitting partition.
          if (fit_rule != STRAT_BEST && fit_rule != STRAT_WORST) break;
        end else if (fit_rule == STRAT_BEST && free_left[j] < free_left[pick]) begin
          pick = j;
        end else if (fit_rule == STRAT_WORST && free_left[j] > free_left[pick]) begin
          pick = j;
        end
      end
    end
    if (pick < 0) return g;
    free_left[pick]   = free_left[pick] - amt;
    g.granted         = 1'b1;
    g.part_number     = PART_NUM_W'(pick + 1);
    g.remaining_after = free_left[pick];
    return g;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  // Compares one result transaction with the oldest expectation.
  function automatic void check_grant();
    grant_t got;
    grant_t want;
    got = '{rsp_if.granted, rsp_if.part_number, rsp_if.remaining_after};
    if (grant_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result %0b/%0d/%0d",
                              got.granted, got.part_number, got.remaining_after));
      return;
    end
    want = grant_q.pop_front();
    if (got.granted !== want.granted || got.part_number !== want.part_number ||
        got.remaining_after !== want.remaining_after) begin
      note_mismatch($sformatf("granted %0b/%0b part %0d/%0d remaining %0d/%0d (exp/act)",
                              want.granted, got.granted, want.part_number,
                              got.part_number, want.remaining_after,
                              got.remaining_after));
    end
  endfunction

  // Result side: check, throttle ready and count cycles in which nothing moves.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_grant();
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      rsp_if.ready <= !idle_now(recv_idle_pct);
    end
  end

  // Watchdog: too long without any transaction on either channel.
  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Offers one request transaction, waits for it to be taken and records the outcome.
  task automatic send_item(input op_e op, input logic [PART_IDX_W-1:0] idx,
                           input logic [SIZE_BITS-1:0] amt, input bit use_typed,
                           input grant_t want);
    grant_t g;
    if (idle_now(send_idle_pct)) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while (idle_now(send_idle_pct));
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.part_index <= idx;
    req_if.amount     <= amt;
    do @(posedge clk_i); while (!req_if.ready);
    g = predict_grant(op, idx, amt);
    grant_q.push_back(use_typed ? want : g);
  endtask

  // Holds off the request side until every outstanding result has arrived.
  task automatic drain_grants();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] value);
    drain_grants();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_STRATEGY) begin
      fit_rule = value[1:0];
    end else begin
      active_parts = value;
    end
  endtask

  // Random transaction, biased towards exact fits, near misses and small equal sizes
  // so that ties and the full range of remainders keep turning up.
  task automatic random_item();
    op_e                   op;
    logic [PART_IDX_W-1:0] idx;
    logic [SIZE_BITS-1:0]  amt;
    int unsigned           lim;
    int unsigned           pick;
    lim  = live_parts();
    op   = ($urandom_range(99, 0) < 35) ? OP_LOAD : OP_ALLOC;
    idx  = PART_IDX_W'($urandom_range(NUM_PARTS - 1, 0));
    if (op == OP_LOAD && lim != 0 && $urandom_range(4, 0) != 0) begin
      idx = PART_IDX_W'($urandom_range(lim - 1, 0));
    end
    pick = (lim != 0) ? $urandom_range(lim - 1, 0) : 0;
    case ($urandom_range(9, 0))
      0:       amt = '0;
      1:       amt = '1;
      2, 3:    amt = (op == OP_LOAD) ? SIZE_BITS'($urandom_range(15, 0)) : free_left[pick];
      4, 5:    amt = SIZE_BITS'($urandom_range(15, 1));
      6, 7:    amt = SIZE_BITS'($urandom_range(1000, 0));
      8:       amt = free_left[pick] + 1'b1;
      default: amt = SIZE_BITS'($urandom());
    endcase
    send_item(op, idx, amt, 1'b0, NOT_GRANTED);
  endtask

  // Main sequence: reset, directed steps, random phases, then wait for the tail.
  initial begin
    int unsigned p;
    int unsigned n;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_LOAD;
    req_if.part_index <= '0;
    req_if.amount     <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_STRATEGY;
    cfg_data_i        <= '0;
    rst_ni            <= 1'b0;
    foreach (free_left[i]) free_left[i] = '0;
    fit_rule      = STRAT_FIRST;
    active_parts  = PARTS_IN_USE_RESET;
    mismatches    = 0;
    send_idle_pct = 28;
    recv_idle_pct = 75;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == DIR_CFG) begin
        write_reg(cfg_reg_e'(DIRECTED[r].sel[CFG_IDX_W-1:0]),
                  DIRECTED[r].val[CFG_DATA_W-1:0]);
      end else begin
        send_item((DIRECTED[r].kind == DIR_ALLOC) ? OP_ALLOC : OP_LOAD, DIRECTED[r].sel,
                  DIRECTED[r].val, DIRECTED[r].typed_check, DIRECTED[r].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      // Sender lightly and receiver heavily idle first, then the other way round, then no idling.
      if (p < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 75;
      end else if (p < 6) begin
        send_idle_pct = 75;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_STRATEGY, CFG_DATA_W'(PHASE_RULE[p]));
      write_reg(CFG_PARTS_IN_USE, PHASE_PARTS[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(199, 0) == 0) drain_grants();
        random_item();
      end
    end

    req_if.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/fpfa_pkg.sv
rtl/core/fpfa_req_if.sv
rtl/core/fpfa_rsp_if.sv
rtl/core/fpfa_ram.sv
rtl/core/fpfa_ctrl.sv
rtl/core/fpfa_dp.sv
rtl/core/fixed_partition_fit_allocator_core.sv
rtl/core/fpfa_checker.sv
dv/tb_fixed_partition_fit_allocator_core.sv
